FILE: hdl/udec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_pkg: shared types and constants for the decimal ASCII converter
// Holds the digit geometry, the saturation limit and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package udec_pkg;

    // Default width of the binary input.
    localparam int INPUT_WIDTH_DEF = 32;

    // Ten decimal digits cover any 33-bit value and the saturation limit.
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int DIGIT_IDX_W = 4;

    // Larger inputs are clamped to ten nines, which needs 34 binary bits.
    localparam int          SAT_WIDTH = 34;
    localparam logic [63:0] SAT_VALUE = 64'd9999999999;

    // ASCII code of the character '0', at the width of the output field.
    localparam int         CHAR_W     = 6;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load;   // capture a new number, clear the digits
        logic                   shift;  // one double dabble step
        logic                   emit;   // load the output register with a digit
        logic                   last;   // the emitted digit ends the run
        logic [DIGIT_IDX_W-1:0] sel;    // which digit to emit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                   out_free; // output register can take a digit
        logic [DIGIT_IDX_W-1:0] top_idx;  // most significant nonzero digit
    } t_status;

endpackage

FILE: hdl/udec_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_ctrl: sequencing for the decimal ASCII converter
// Runs the load, the bit-serial conversion, the digit count and the digit
// emission, and tells the datapath what to do in each cycle.
// ----------------------------------------------------------------------------
module udec_ctrl import udec_pkg::*; #(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    // Only the low bits of a clamped value need converting.
    localparam int SH_W = (INPUT_WIDTH > SAT_WIDTH) ? SAT_WIDTH : INPUT_WIDTH;
    localparam int CNT_W = $clog2(SH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SH_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIGIT_IDX_W-1:0] r_idx, n_idx;
    logic                   accept;

    // A new transaction is taken only while idle.
    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.sel  = r_idx;
        o_cmd.last = (r_idx == '0);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_LAST;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_idx   = i_status.top_idx;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register; the counters are only meaningful inside a run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    // A digit leaves only from the emission state.
    a_emit_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == ST_EMIT))
        else $error("digit emitted outside the emission state");

    // An accepted transaction always starts a conversion.
    a_load_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_CONV))
        else $error("load not followed by conversion");

    // The digit count state is always followed by the emission state.
    a_size_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIZE) |=> (r_state == ST_EMIT))
        else $error("digit count not followed by emission");

    // The digit index never points past the last digit.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx < DIGIT_IDX_W'(MAX_DIGITS)))
        else $error("digit index out of range");

endmodule

FILE: hdl/udec_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_dpath: datapath of the decimal ASCII converter
// Clamps and holds the binary value, converts it to packed BCD one bit per
// cycle by double dabble, and drives the output register.
// ----------------------------------------------------------------------------
module udec_dpath import udec_pkg::*; #(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [INPUT_WIDTH-1:0] i_number,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last
);

    localparam int SH_W = (INPUT_WIDTH > SAT_WIDTH) ? SAT_WIDTH : INPUT_WIDTH;

    logic [SH_W-1:0]   r_bin, n_bin;
    t_bcd              r_bcd, n_bcd;
    t_bcd              adj;
    logic [MAX_DIGITS*DIGIT_W-1:0] adj_flat;
    logic [63:0]       in_ext;
    logic              sat;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_digit_char;
    logic              r_last;

    // Clamp inputs beyond ten decimal digits.
    assign in_ext = 64'(i_number);
    assign sat    = (in_ext > SAT_VALUE);

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            adj[d] = (r_bcd[d] >= DIGIT_W'(5)) ? (r_bcd[d] + DIGIT_W'(3)) : r_bcd[d];
        end
    end

    // Flat view of the adjusted digits for the one-bit shift.
    assign adj_flat = adj;

    // Binary and BCD registers.
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_bin = sat ? SAT_VALUE[SH_W-1:0] : in_ext[SH_W-1:0];
            n_bcd = '0;
        end else if (i_cmd.shift) begin
            n_bin = {r_bin[SH_W-2:0], 1'b0};
            n_bcd = {adj_flat[MAX_DIGITS*DIGIT_W-2:0], r_bin[SH_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    // Highest nonzero digit; zero still yields one digit.
    always_comb begin
        o_status.top_idx = '0;
        for (int d = 1; d < MAX_DIGITS; d++) begin
            if (r_bcd[d] != '0) begin
                o_status.top_idx = DIGIT_IDX_W'(d);
            end
        end
    end

    // The output register takes a digit when empty or being drained.
    assign o_status.out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.emit) begin
            r_digit_char <= ASCII_ZERO + CHAR_W'(r_bcd[i_cmd.sel]);
            r_last       <= i_cmd.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_digit_char;
    assign o_last       = r_last;

    // A digit never overwrites one that is still held.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // Every loaded digit is an ASCII decimal character.
    a_emit_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && (r_digit_char >= ASCII_ZERO)
                        && (r_digit_char <= ASCII_ZERO + CHAR_W'(9))))
        else $error("emitted character is not a decimal digit");

    // A load starts from an all-zero BCD accumulator.
    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_bcd == '0))
        else $error("BCD accumulator not cleared on load");

endmodule

FILE: hdl/unsigned_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii: unsigned binary to decimal ASCII text
// Converts one unsigned number into its decimal digits as ASCII characters,
// most significant first, without leading zeros, last digit flagged.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, i_number, o_stall) takes one number per
//   transaction. The output channel (o_valid, o_digit_char, o_last, i_stall)
//   returns one character per transaction; o_last marks the final digit.
//   Zero gives the single character '0'. Values above 9999999999 (possible
//   only with INPUT_WIDTH above 33) are clamped to ten nines.
//   Sequence: the number is loaded, its low min(INPUT_WIDTH, 34) bits are
//   converted by bit-serial double dabble, the result is sized, and then
//   one digit is emitted per cycle while the output register is free. At
//   the default width a number gives from 1 to 10 digits.
//   o_stall is high from acceptance until the last digit sits in the output
//   register; the next number may enter while that digit is still held.
//   While i_stall is high the held character stays and emission pauses.
//   Reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii import udec_pkg::*; #(
    parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [INPUT_WIDTH-1:0] i_number,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last,
    input  logic                   i_stall
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    udec_ctrl #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Conversion registers and output stage.
    udec_dpath #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_number     (i_number),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
